>>> hw/rtl/ber_tlv_stream_parser_macros.svh
// Assertion macros for the BER TLV stream parser.
// Used by ber_tlv_stream_parser.sv; expects clk and rst_n in scope.
`ifndef BER_TLV_STREAM_PARSER_MACROS_SVH
`define BER_TLV_STREAM_PARSER_MACROS_SVH

// cons must hold in the same cycle as cond
`define BTSP_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after cond
`define BTSP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/btsp_pkg.sv
// Shared constants and codes for the BER TLV stream parser.
// No dependencies; used by ber_tlv_stream_parser.sv.
package btsp_pkg;

    localparam int MAX_DEPTH     = 8;
    localparam int MAX_PER_LEVEL = 16;
    localparam int OFFSET_BITS   = 16;

    // derived widths
    localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
    localparam int ESTK_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_PER_LEVEL + 1);
    localparam int LEN_W  = 16;
    localparam int SUM_W  = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;

    // tag / length byte fields
    localparam int TAG_CONS_BIT = 5;
    localparam int LEN_LONG_BIT = 7;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_HDR     = 2'd0;
    localparam kind_t KIND_CONTENT = 2'd1;
    localparam kind_t KIND_ERR     = 2'd2;

    typedef logic [1:0] err_t;
    localparam err_t ERR_NONE    = 2'd0;
    localparam err_t ERR_TRUNC   = 2'd1;
    localparam err_t ERR_OVERRUN = 2'd2;
    localparam err_t ERR_DEPTH   = 2'd3;

endpackage

>>> hw/rtl/ber_tlv_stream_parser.sv
// BER TLV stream parser: one message byte in, at most one record out per byte.
// Depends on btsp_pkg.sv and ber_tlv_stream_parser_macros.svh.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one message byte per request,
//   with last_byte marking the final byte of a message. Output channel
//   (result_valid / result_stall) carries element headers, primitive content
//   bytes and error records.
//   Timing: a byte is registered in the input register on accept; its record,
//   if any, is registered in the result register that drives the result port.
//   Throughput: one byte per cycle while no record is stalled; all work for
//   a byte is one pass of logic from the input register to the result register.
//   Open levels are closed by comparing every stacked end offset in parallel.
//   Stall: when the result register holds a record that is stalled, the input
//   register cannot drain and item_stall rises; nothing is dropped.
//   Reset: rst_n clears the parse state, the pipeline valids and the level
//   counters. The level end stack is not cleared; only pushed entries are read.
//   After the last byte of a message the parser returns to its reset state.
module ber_tlv_stream_parser
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [1:0]             kind,
    output logic [7:0]             tag,
    output logic [15:0]            length,
    output logic [3:0]             depth,
    output logic [15:0]            content_offset,
    output logic                   constructed,
    output logic [3:0]             index_in_level,
    output logic [7:0]             content_byte,
    output logic [1:0]             error_code,
    output logic                   end_of_input
);

`include "ber_tlv_stream_parser_macros.svh"

    localparam int OFF_W = btsp_pkg::OFFSET_BITS;
    localparam int LVL_W = btsp_pkg::LVL_W;
    localparam int EST_W = btsp_pkg::ESTK_W;
    localparam int CNT_W = btsp_pkg::CNT_W;
    localparam int LEN_W = btsp_pkg::LEN_W;
    localparam int SUM_W = btsp_pkg::SUM_W;
    localparam int NDEP  = btsp_pkg::MAX_DEPTH;

    // parse phases
    localparam logic [2:0] PH_TAG     = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_LONG    = 3'd2;
    localparam logic [2:0] PH_CONTENT = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;
    localparam logic [2:0] PH_ERR     = 3'd5;

    // ---------------- input register ----------------
    logic       s1_valid_reg;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       out_free;
    logic       s1_fire;

    // result register can take a new record (or drop the old one)
    assign out_free   = !result_valid || !result_stall;
    assign s1_fire    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // ---------------- parse state ----------------
    logic [2:0]       phase_reg,  phase_next;
    logic [7:0]       tag_reg,    tag_next;
    logic [LEN_W-1:0] len_reg,    len_next;
    logic [6:0]       left_reg,   left_next;
    logic [OFF_W-1:0] offset_reg;
    logic [OFF_W-1:0] eend_reg,   eend_next;
    logic [LVL_W-1:0] level_reg,  level_next;
    logic [OFF_W-1:0] estk_reg [NDEP];
    logic [CNT_W-1:0] cnt_reg  [NDEP+1];

    logic [OFF_W-1:0] nxt_off;
    logic [LVL_W-1:0] lv;
    logic [CNT_W-1:0] cnt_cur;
    logic [6:0]       left_dec;
    logic             finish;
    logic             emit_content;
    logic             cons;
    logic [SUM_W-1:0] end_full;
    logic [OFF_W-1:0] end_off;
    logic [OFF_W-1:0] parent_end;
    logic             overrun;
    logic             too_deep;
    logic             hdr_ok;
    logic             push;
    logic [LVL_W-1:0] lvl_after;
    logic [OFF_W-1:0] estk_after [NDEP];
    logic             still;
    logic             trunc;
    btsp_pkg::err_t   err;

    assign nxt_off    = offset_reg + OFF_W'(1);
    assign lv         = level_reg;
    assign cnt_cur    = cnt_reg[lv];
    assign parent_end = estk_reg[EST_W'(lv - LVL_W'(1))];

    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        eend_next    = eend_reg;
        finish       = 1'b0;
        emit_content = 1'b0;
        left_dec     = (left_reg != 7'd0) ? (left_reg - 7'd1) : 7'd0;

        case (phase_reg)
            PH_TAG:
            begin
                if (cnt_cur >= CNT_W'(btsp_pkg::MAX_PER_LEVEL))
                begin
                    phase_next = PH_SKIP;
                end
                else
                begin
                    tag_next   = s1_data_reg;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (s1_data_reg[btsp_pkg::LEN_LONG_BIT])
                begin
                    len_next  = '0;
                    left_next = s1_data_reg[6:0];
                    if (s1_data_reg[6:0] == 7'd0)
                    begin
                        finish = 1'b1;        // indefinite form taken as empty
                    end
                    else
                    begin
                        phase_next = PH_LONG;
                    end
                end
                else
                begin
                    len_next = LEN_W'(s1_data_reg);
                    finish   = 1'b1;
                end
            end
            PH_LONG:
            begin
                len_next  = {len_reg[LEN_W-9:0], s1_data_reg};
                left_next = left_dec;
                finish    = (left_dec == 7'd0);
            end
            PH_CONTENT:
            begin
                emit_content = 1'b1;
                if (nxt_off == eend_reg)
                begin
                    phase_next = PH_TAG;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // element header complete
        cons     = tag_reg[btsp_pkg::TAG_CONS_BIT];
        end_full = SUM_W'(nxt_off) + SUM_W'(len_next);
        end_off  = end_full[OFF_W-1:0];
        overrun  = finish && (lv != '0) && (end_full > SUM_W'(parent_end));
        too_deep = finish && !overrun && cons && (len_next != '0) &&
                   (lv >= LVL_W'(NDEP));
        hdr_ok   = finish && !overrun && !too_deep;
        push     = hdr_ok && cons && (len_next != '0);

        if (hdr_ok)
        begin
            if (push)
            begin
                phase_next = PH_TAG;
            end
            else if (len_next != '0)
            begin
                eend_next  = end_off;
                phase_next = PH_CONTENT;
            end
            else
            begin
                phase_next = PH_TAG;
            end
        end

        lvl_after = push ? (lv + LVL_W'(1)) : lv;
        for (int i = 0; i < NDEP; i++)
        begin
            estk_after[i] = (push && (LVL_W'(i) == lv)) ? end_off : estk_reg[i];
        end

        if (overrun)
        begin
            err = btsp_pkg::ERR_OVERRUN;
        end
        else if (too_deep)
        begin
            err = btsp_pkg::ERR_DEPTH;
        end
        else
        begin
            err = btsp_pkg::ERR_NONE;
        end

        // close every level whose end is reached at this offset
        level_next = lvl_after;
        still      = (err == btsp_pkg::ERR_NONE) &&
                     ((phase_next == PH_TAG) || (phase_next == PH_SKIP));
        for (int i = NDEP - 1; i >= 0; i--)
        begin
            if (LVL_W'(i) < lvl_after)
            begin
                if (still && (estk_after[i] == nxt_off))
                begin
                    level_next = LVL_W'(i);
                end
                else
                begin
                    still = 1'b0;
                end
            end
        end
        if (level_next != lvl_after)
        begin
            phase_next = PH_TAG;
        end

        if (err != btsp_pkg::ERR_NONE)
        begin
            phase_next = PH_ERR;
        end

        trunc = s1_last_reg && (err == btsp_pkg::ERR_NONE) && (phase_next != PH_ERR) &&
                !(((phase_next == PH_TAG) || (phase_next == PH_SKIP)) &&
                  (level_next == '0));
        if (trunc)
        begin
            err = btsp_pkg::ERR_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG;
            tag_reg    <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            offset_reg <= '0;
            eend_reg   <= '0;
            level_reg  <= '0;
            for (int i = 0; i <= NDEP; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                // message done: back to reset state
                phase_reg  <= PH_TAG;
                tag_reg    <= '0;
                len_reg    <= '0;
                left_reg   <= '0;
                offset_reg <= '0;
                eend_reg   <= '0;
                level_reg  <= '0;
                for (int i = 0; i <= NDEP; i++)
                begin
                    cnt_reg[i] <= '0;
                end
            end
            else
            begin
                phase_reg  <= phase_next;
                tag_reg    <= tag_next;
                len_reg    <= len_next;
                left_reg   <= left_next;
                offset_reg <= nxt_off;
                eend_reg   <= eend_next;
                level_reg  <= level_next;
                for (int i = 0; i <= NDEP; i++)
                begin
                    if (hdr_ok && (LVL_W'(i) == lv))
                    begin
                        cnt_reg[i] <= cnt_cur + CNT_W'(1);
                    end
                    else if (push && (LVL_W'(i) == lvl_after))
                    begin
                        cnt_reg[i] <= '0;
                    end
                end
            end
        end
    end

    // level end stack: no reset, entries are read only after a push
    always_ff @(posedge clk)
    begin
        if (s1_fire && push && !s1_last_reg)
        begin
            estk_reg[EST_W'(lv)] <= end_off;
        end
    end

    // ---------------- result register ----------------
    logic        rv_reg;
    logic        emit;
    logic [1:0]  kind_reg;
    logic [7:0]  tag_out_reg;
    logic [15:0] len_out_reg;
    logic [3:0]  depth_reg;
    logic [15:0] coff_reg;
    logic        cons_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  cbyte_reg;
    logic [1:0]  ecode_reg;
    logic        eoi_reg;
    logic [OFF_W-1:0] content_start;

    assign emit          = (err != btsp_pkg::ERR_NONE) || hdr_ok || emit_content;
    assign content_start = eend_reg - OFF_W'(len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rv_reg <= s1_valid_reg && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            eoi_reg <= s1_last_reg;
            if (err != btsp_pkg::ERR_NONE)
            begin
                kind_reg    <= btsp_pkg::KIND_ERR;
                tag_out_reg <= tag_next;
                len_out_reg <= '0;
                depth_reg   <= 4'(level_next);
                coff_reg    <= '0;
                cons_reg    <= 1'b0;
                idx_reg     <= '0;
                cbyte_reg   <= '0;
                ecode_reg   <= err;
            end
            else if (hdr_ok)
            begin
                kind_reg    <= btsp_pkg::KIND_HDR;
                tag_out_reg <= tag_reg;
                len_out_reg <= 16'(len_next);
                depth_reg   <= 4'(lv);
                coff_reg    <= 16'(nxt_off);
                cons_reg    <= cons;
                idx_reg     <= 4'(cnt_cur);
                cbyte_reg   <= '0;
                ecode_reg   <= btsp_pkg::ERR_NONE;
            end
            else
            begin
                kind_reg    <= btsp_pkg::KIND_CONTENT;
                tag_out_reg <= tag_reg;
                len_out_reg <= 16'(len_reg);
                depth_reg   <= 4'(lv);
                coff_reg    <= 16'(content_start);
                cons_reg    <= 1'b0;
                idx_reg     <= (cnt_cur != '0) ? 4'(cnt_cur - CNT_W'(1)) : 4'd0;
                cbyte_reg   <= s1_data_reg;
                ecode_reg   <= btsp_pkg::ERR_NONE;
            end
        end
    end

    assign result_valid   = rv_reg;
    assign kind           = kind_reg;
    assign tag            = tag_out_reg;
    assign length         = len_out_reg;
    assign depth          = depth_reg;
    assign content_offset = coff_reg;
    assign constructed    = cons_reg;
    assign index_in_level = idx_reg;
    assign content_byte   = cbyte_reg;
    assign error_code     = ecode_reg;
    assign end_of_input   = eoi_reg;

    // ---------------- assertions ----------------
    `BTSP_ASSERT_NOW(a_err_kind, result_valid,
        ((kind == btsp_pkg::KIND_ERR) == (error_code != btsp_pkg::ERR_NONE)),
        "error code does not match record kind")
    `BTSP_ASSERT_NOW(a_stall_cause, item_stall, (result_valid && result_stall),
        "input stalled while result register is free")
    `BTSP_ASSERT_NOW(a_level_bound, 1'b1, (level_reg <= LVL_W'(NDEP)),
        "nesting level beyond stack bound")
    `BTSP_ASSERT_NOW(a_count_bound, 1'b1,
        (cnt_cur <= CNT_W'(btsp_pkg::MAX_PER_LEVEL)),
        "sibling count beyond level limit")
    `BTSP_ASSERT_NEXT(a_msg_restart, (s1_fire && s1_last_reg),
        ((phase_reg == PH_TAG) && (level_reg == '0) && (offset_reg == '0)),
        "parser not back in start state after last byte")

endmodule

>>> test/tlv_parse_check_pkg.sv
// Record type and checker class for the BER TLV stream parser testbench.
// Depends on btsp_pkg (widths, record kinds, error codes).
package tlv_parse_check_pkg;

    import btsp_pkg::*;

    typedef enum logic [2:0] {
        AT_TAG,
        AT_LEN,
        AT_LONG_LEN,
        AT_CONTENT,
        AT_SKIP,
        AT_ERROR
    } parse_phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tag;
        logic [15:0] length;
        logic [3:0]  depth;
        logic [15:0] content_offset;
        logic        constructed;
        logic [3:0]  index_in_level;
        logic [7:0]  content_byte;
        err_t        error_code;
        logic        end_of_input;
    } tlv_record_t;

    // Tracks the parse of the byte stream and holds the records it calls for.
    class tlv_record_checker_t;
        tlv_record_t  pending_records[$];
        int unsigned  failures;

        parse_phase_t phase;
        logic [7:0]   tag_hold;
        logic [15:0]  length_acc;
        logic [6:0]   len_bytes_left;
        logic [15:0]  byte_offset;
        logic [15:0]  element_end;
        int unsigned  level;
        logic [15:0]  level_ends[MAX_DEPTH];
        int unsigned  level_counts[MAX_DEPTH + 1];

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase          = AT_TAG;
            tag_hold       = '0;
            length_acc     = '0;
            len_bytes_left = '0;
            byte_offset    = '0;
            element_end    = '0;
            level          = 0;
            foreach (level_ends[i])
                level_ends[i] = '0;
            foreach (level_counts[i])
                level_counts[i] = 0;
        endfunction

        // Advance the parse by one accepted byte; queue the record it causes.
        // Returns 0 for a byte the parser ignores (skipped level, after an error).
        function bit note_byte(logic [7:0] b, logic lst);
            logic [15:0] next_off;
            logic [16:0] end_sum;
            bit          finish;
            bit          cons;
            bit          have;
            bit          parsed;
            err_t        err;
            tlv_record_t rec;
            int unsigned lv;
            int unsigned idx;
            next_off = byte_offset + 16'd1;
            finish   = 1'b0;
            have     = 1'b0;
            err      = ERR_NONE;
            rec      = '0;
            parsed   = (phase != AT_SKIP) && (phase != AT_ERROR);
            lv       = (level > MAX_DEPTH) ? MAX_DEPTH : level;
            case (phase)
                AT_TAG:
                    if (level_counts[lv] >= MAX_PER_LEVEL)
                        phase = AT_SKIP;
                    else
                    begin
                        tag_hold = b;
                        phase    = AT_LEN;
                    end
                AT_LEN:
                begin
                    length_acc = '0;
                    if (b[LEN_LONG_BIT])
                    begin
                        len_bytes_left = b[6:0];
                        if (len_bytes_left == 0)
                            finish = 1'b1;
                        else
                            phase = AT_LONG_LEN;
                    end
                    else
                    begin
                        length_acc = {8'd0, b};
                        finish     = 1'b1;
                    end
                end
                AT_LONG_LEN:
                begin
                    length_acc = {length_acc[7:0], b};
                    if (len_bytes_left > 0)
                        len_bytes_left--;
                    if (len_bytes_left == 0)
                        finish = 1'b1;
                end
                AT_CONTENT:
                begin
                    idx                = level_counts[lv];
                    rec.kind           = KIND_CONTENT;
                    rec.tag            = tag_hold;
                    rec.length         = length_acc;
                    rec.depth          = 4'(lv);
                    rec.content_offset = element_end - length_acc;
                    rec.index_in_level = 4'((idx > 0) ? idx - 1 : 0);
                    rec.content_byte   = b;
                    rec.end_of_input   = lst;
                    have               = 1'b1;
                    if (next_off == element_end)
                        phase = AT_TAG;
                end
                default: ;
            endcase

            if (finish)
            begin
                end_sum = {1'b0, next_off} + {1'b0, length_acc};
                cons    = tag_hold[TAG_CONS_BIT];
                if (lv > 0 && end_sum > {1'b0, level_ends[lv - 1]})
                    err = ERR_OVERRUN;
                else if (cons && length_acc != 0 && lv >= MAX_DEPTH)
                    err = ERR_DEPTH;
                else
                begin
                    rec                = '0;
                    rec.kind           = KIND_HDR;
                    rec.tag            = tag_hold;
                    rec.length         = length_acc;
                    rec.depth          = 4'(lv);
                    rec.content_offset = next_off;
                    rec.constructed    = cons;
                    rec.index_in_level = 4'(level_counts[lv]);
                    rec.end_of_input   = lst;
                    have               = 1'b1;
                    level_counts[lv]++;
                    if (cons && length_acc != 0)
                    begin
                        level_ends[lv]      = end_sum[15:0];
                        level               = lv + 1;
                        level_counts[level] = 0;
                        phase               = AT_TAG;
                    end
                    else if (length_acc != 0)
                    begin
                        element_end = end_sum[15:0];
                        phase       = AT_CONTENT;
                    end
                    else
                        phase = AT_TAG;
                end
            end

            byte_offset = next_off;

            // several levels may close on the same byte
            if (err == ERR_NONE && (phase == AT_TAG || phase == AT_SKIP))
                while (level > 0 && level <= MAX_DEPTH && level_ends[level - 1] == byte_offset)
                begin
                    level--;
                    phase = AT_TAG;
                end

            if (err != ERR_NONE)
                phase = AT_ERROR;

            if (lst && err == ERR_NONE && phase != AT_ERROR &&
                !((phase == AT_TAG || phase == AT_SKIP) && level == 0))
                err = ERR_TRUNC;

            if (err != ERR_NONE)
            begin
                rec              = '0;
                rec.kind         = KIND_ERR;
                rec.tag          = tag_hold;
                rec.depth        = 4'((level > MAX_DEPTH) ? MAX_DEPTH : level);
                rec.error_code   = err;
                rec.end_of_input = lst;
                have             = 1'b1;
            end

            if (have)
                pending_records.push_back(rec);
            if (lst)
                clear_state();
            return parsed;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_record(tlv_record_t got);
            tlv_record_t want;
            if (pending_records.size() == 0)
            begin
                $error("record with none pending: kind %0d tag %0h", got.kind, got.tag);
                failures++;
                return;
            end
            want = pending_records.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("tag", want.tag, got.tag);
            compare_field("length", want.length, got.length);
            compare_field("depth", want.depth, got.depth);
            compare_field("content_offset", want.content_offset, got.content_offset);
            compare_field("constructed", want.constructed, got.constructed);
            compare_field("index_in_level", want.index_in_level, got.index_in_level);
            compare_field("content_byte", want.content_byte, got.content_byte);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("end_of_input", want.end_of_input, got.end_of_input);
        endfunction
    endclass

endpackage

>>> test/ber_tlv_stream_parser_test.sv
// Testbench for ber_tlv_stream_parser: directed and random BER messages, records checked.
// Depends on btsp_pkg, tlv_parse_check_pkg and the parser RTL.
module ber_tlv_stream_parser_test;

    import btsp_pkg::*;
    import tlv_parse_check_pkg::*;

    localparam int HALF_PERIOD  = 6;
    // Quiet-cycle limit. Sender and receiver gaps are geometric (at most 84% idle),
    // so a long run of quiet cycles is already rare; this limit is far beyond it.
    localparam int QUIET_LIMIT  = 4000;
    // Margin to allow after the last record has been checked.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 550;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic [7:0]  data_byte    = '0;
    logic        last_byte    = 1'b0;
    logic        result_stall = 1'b0;

    logic        item_stall;
    logic        result_valid;
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [15:0] length;
    logic [3:0]  depth;
    logic [15:0] content_offset;
    logic        constructed;
    logic [3:0]  index_in_level;
    logic [7:0]  content_byte;
    logic [1:0]  error_code;
    logic        end_of_input;

    tlv_record_t         seen_record;
    tlv_record_checker_t board;

    int send_idle_pct = 37;
    int recv_idle_pct = 84;
    int parsed_bytes  = 0;
    int quiet_cycles  = 0;

    // Shape knobs for the message generator, set per message.
    int tree_depth  = 1;
    int chain_depth = 0;
    int wide_level  = -1;
    bit broken      = 1'b0;

    logic [7:0] msg_bytes[$];

    ber_tlv_stream_parser dut (.*);

    assign seen_record = {kind, tag, length, depth, content_offset, constructed,
                          index_in_level, content_byte, error_code, end_of_input};

    always #HALF_PERIOD clk = ~clk;

    // Result side: check each accepted record, then pick the next stall.
    // Values read here are the ones from before this edge.
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
            board.check_record(seen_record);
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One byte request. Called at a rising edge; returns at the edge that accepts it.
    task automatic send_byte(logic [7:0] b, logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= lst;
        do
            @(posedge clk);
        while (item_stall);
        if (board.note_byte(b, lst))
            parsed_bytes++;
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Append one TLV element at nesting level lvl. Content is built first so the
    // length can be encoded in front of it. In broken messages the declared
    // length is sometimes off by a byte or two, so children overrun or fall short.
    function automatic void emit_element(int lvl, ref logic [7:0] out_q[$]);
        logic [7:0] body[$];
        logic [7:0] tag_b;
        int         n_kids;
        int         declared;
        int         n_len;
        int         form;
        int         k;
        bit         cons;
        tag_b  = 8'($urandom);
        n_kids = 0;
        if (lvl + 1 == wide_level)
        begin
            // close to enough siblings to fill the level: sometimes fewer, sometimes more
            cons   = 1'b1;
            n_kids = $urandom_range(15, 18);
        end
        else if (lvl < chain_depth)
        begin
            cons   = 1'b1;
            n_kids = 1;
        end
        else if (lvl < tree_depth || lvl == chain_depth)
        begin
            // innermost link of a deep chain may be constructed at the depth bound
            cons   = ($urandom_range(0, 2) == 0);
            n_kids = $urandom_range(0, 3);
        end
        else
            cons = 1'b0;
        tag_b[TAG_CONS_BIT] = cons;

        if (cons)
            for (k = 0; k < n_kids; k++)
                emit_element(lvl + 1, body);
        else
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6))
                body.push_back(8'($urandom));

        declared = body.size();
        if (broken && $urandom_range(0, 2) == 0)
        begin
            declared = declared + $urandom_range(0, 4) - 2;
            if (declared < 0)
                declared = 0;
        end

        out_q.push_back(tag_b);
        form = $urandom_range(0, 9);
        if (declared == 0 && form == 0)
            out_q.push_back(8'h80);             // indefinite form
        else if (declared < 128 && form < 6)
            out_q.push_back(8'(declared));
        else
        begin
            // long form; bytes above the low two are arbitrary since only 16 bits count
            if (form == 9 && $urandom_range(0, 3) == 0)
                n_len = $urandom_range(64, 127);
            else
                n_len = $urandom_range((declared > 255) ? 2 : 1, 3);
            out_q.push_back(8'h80 | 8'(n_len));
            for (k = n_len - 1; k >= 0; k--)
                out_q.push_back((k >= 2) ? 8'($urandom) : 8'(declared >> (8 * k)));
        end
        foreach (body[i])
            out_q.push_back(body[i]);
    endfunction

    // Mostly well-formed trees; some deep chains, full levels, truncated or
    // broken lengths, and pure noise.
    function automatic void build_random_message();
        int style;
        int top_count;
        int cut;
        int k;
        msg_bytes.delete();
        tree_depth  = $urandom_range(1, 3);
        chain_depth = 0;
        wide_level  = -1;
        broken      = 1'b0;
        top_count   = $urandom_range(1, 3);
        style       = $urandom_range(0, 99);
        if (style < 10)
            chain_depth = $urandom_range(MAX_DEPTH - 2, MAX_DEPTH);
        else if (style < 18)
        begin
            wide_level = $urandom_range(0, 1);
            tree_depth = 1;
            if (wide_level == 0)
                top_count = $urandom_range(15, 19);
        end
        else if (style < 30)
            broken = 1'b1;
        else if (style < 38)
        begin
            repeat ($urandom_range(1, 12))
                msg_bytes.push_back(8'($urandom));
            return;
        end

        for (k = 0; k < top_count; k++)
            emit_element(0, msg_bytes);

        if (style >= 38 && style < 52)
        begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end
    endfunction

    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages.
        // Lone tag byte: message ends inside the length.
        msg_bytes = '{8'hFF};
        send_message();
        // Zero tag, empty primitive.
        msg_bytes = '{8'h00, 8'h00};
        send_message();
        // Indefinite length on a constructed tag: empty, opens no level.
        msg_bytes = '{8'h24, 8'h80};
        send_message();
        // Largest length, then cut off: truncation replaces the content record.
        msg_bytes = '{8'h04, 8'h82, 8'hFF, 8'hFF, 8'hAB};
        send_message();
        // One nested primitive; the level closes on the last byte.
        msg_bytes = '{8'h30, 8'h03, 8'h04, 8'h01, 8'hFF};
        send_message();
        // Child runs past its parent; later bytes are ignored.
        msg_bytes = '{8'h30, 8'h02, 8'h04, 8'h05, 8'h00};
        send_message();
        // Three length bytes, only the low 16 bits kept.
        msg_bytes = '{8'h04, 8'h83, 8'h12, 8'h00, 8'h01, 8'h5A};
        send_message();

        // Random messages in three idling regimes.
        parsed_bytes = 0;
        while (parsed_bytes < RANDOM_BYTES)
        begin
            if (parsed_bytes < RANDOM_BYTES / 3)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 84;
            end
            else if (parsed_bytes < 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            build_random_message();
            send_message();
        end
        item_valid <= 1'b0;

        while (board.pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
